@@ design/tfpt_pkg.sv @@
// tfpt_pkg: shared types and fixed field widths of the tlb page translator
// used by the channel interfaces and the top level; no dependencies

package tfpt_pkg;

	localparam int unsigned ADDR_W = 16;
	localparam int unsigned IDX_W  = 8;
	localparam int unsigned CNT_W  = 32;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BUSY
	} state_t;

endpackage

@@ design/tfpt_if.sv @@
// tfpt_req_if / tfpt_rsp_if: valid/ready channels of the tlb page translator
// depends on tfpt_pkg for the field widths

interface tfpt_req_if;
	logic                        valid;
	logic                        ready;
	logic [tfpt_pkg::ADDR_W-1:0] vaddr;

	modport source (output valid, output vaddr, input ready);
	modport sink   (input valid, input vaddr, output ready);
endinterface

interface tfpt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tfpt_pkg::ADDR_W-1:0] physical_address;
	logic [tfpt_pkg::IDX_W-1:0]  page_index;
	logic [tfpt_pkg::IDX_W-1:0]  frame_index;
	logic                        tlb_hit;
	logic                        fault_flag;
	logic                        frames_exhausted;
	logic [tfpt_pkg::CNT_W-1:0]  hit_count;
	logic [tfpt_pkg::CNT_W-1:0]  fault_count;
	logic [tfpt_pkg::CNT_W-1:0]  reference_count;

	modport source (
		output valid, output physical_address, output page_index, output frame_index,
		output tlb_hit, output fault_flag, output frames_exhausted,
		output hit_count, output fault_count, output reference_count,
		input ready
	);
	modport sink (
		input valid, input physical_address, input page_index, input frame_index,
		input tlb_hit, input fault_flag, input frames_exhausted,
		input hit_count, input fault_count, input reference_count,
		output ready
	);
endinterface

@@ design/tfpt_ram.sv @@
// tfpt_ram: generic single-clock ram, one write and one read port, registered read
// no dependencies

module tfpt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/tlb_fifo_page_translator_unit.sv @@
// tlb_fifo_page_translator_unit: top level of the tlb page translator
// depends on tfpt_pkg, tfpt_req_if, tfpt_rsp_if and tfpt_ram

// Translates one 16-bit virtual address per request into a physical address.
// The upper bits above OFFSET_BITS form the page number (wrapped modulo
// PAGE_COUNT), looked up in a fully associative TLB of TLB_ENTRIES slots. A
// miss goes to the page table, held in one synchronous ram of PAGE_COUNT
// entries (valid bit plus frame). An unmapped page gets the lowest free frame
// and counts as a page fault; when all FRAME_COUNT frames are used the result
// flags frames_exhausted and uses frame 0. Every miss fills the TLB slot under
// a round-robin pointer. Frames are never freed. Each request has an accept
// step and a resolve step: the accept cycle computes the page, compares all
// TLB slots and starts the page table read; the resolve step then resolves
// the frame, writes the page table back on a fault and loads the result
// register. Both steps go through the single page table ram, so a new request
// is taken once the previous one has resolved. A request is still accepted
// while the last result waits to be taken; resolution waits only if that
// result is not taken by then. After reset a clearing pass walks all
// PAGE_COUNT page table entries (256 by default) before the first request is
// accepted. The hit, fault and reference counts saturate at all ones.

module tlb_fifo_page_translator_unit #(
	parameter int unsigned OFFSET_BITS = 8,
	parameter int unsigned PAGE_COUNT  = 256,
	parameter int unsigned FRAME_COUNT = 256,
	parameter int unsigned TLB_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	tfpt_req_if.sink    req,
	tfpt_rsp_if.source  rsp
);

	// derived widths
	localparam int unsigned ADDR_W  = tfpt_pkg::ADDR_W;
	localparam int unsigned CNT_W   = tfpt_pkg::CNT_W;
	localparam int unsigned IDX_W   = tfpt_pkg::IDX_W;
	localparam int unsigned VPN_W   = (OFFSET_BITS < ADDR_W) ? ADDR_W - OFFSET_BITS : 1;
	localparam int unsigned PAGE_W  = $clog2(PAGE_COUNT);
	localparam int unsigned FRAME_W = $clog2(FRAME_COUNT);
	localparam int unsigned NF_W    = $clog2(FRAME_COUNT + 1);
	localparam int unsigned TLB_W   = $clog2(TLB_ENTRIES);
	localparam int unsigned MAP_W   = FRAME_W + 1;

	// reciprocal of PAGE_COUNT, rounded up, exact for every VPN_W-bit page number
	localparam int unsigned     RCP_S  = VPN_W + PAGE_W;
	localparam int unsigned     RCP_W  = VPN_W + 2;
	localparam int unsigned     PROD_W = VPN_W + RCP_W;
	localparam longint unsigned RCP_M  =
		((64'd1 << RCP_S) + 64'(PAGE_COUNT) - 64'd1) / 64'(PAGE_COUNT);

	// page number modulo PAGE_COUNT by reciprocal multiplication
	function automatic logic [PAGE_W-1:0] page_of(input logic [VPN_W-1:0] vpn);
		logic [PROD_W-1:0] prod;
		logic [VPN_W-1:0]  quot;
		logic [VPN_W-1:0]  rem;
		prod = PROD_W'(vpn) * PROD_W'(RCP_M);
		quot = VPN_W'(prod >> RCP_S);
		rem  = vpn - VPN_W'(quot * VPN_W'(PAGE_COUNT));
		return PAGE_W'(rem);
	endfunction

	// control state
	tfpt_pkg::state_t  state_q, state_d;
	logic [PAGE_W-1:0] clr_q;
	logic              accept, done, clr_last;

	// request registers
	logic [ADDR_W-1:0]      va_s1;
	logic [PAGE_W-1:0]      page_s1;
	logic [TLB_ENTRIES-1:0] match_s1;

	// tlb storage
	logic                   tlb_valid_q [TLB_ENTRIES];
	logic [PAGE_W-1:0]      tlb_page_q  [TLB_ENTRIES];
	logic [FRAME_W-1:0]     tlb_frame_q [TLB_ENTRIES];
	logic [TLB_W-1:0]       fifo_q;

	// allocation and counters
	logic [NF_W-1:0]  next_free_q;
	logic [CNT_W-1:0] hits_q, faults_q, refs_q;

	// page table ram
	logic              ram_we, ram_re;
	logic [PAGE_W-1:0] ram_waddr;
	logic [MAP_W-1:0]  ram_wdata, ram_rdata;

	// accept-cycle lookup
	logic [ADDR_W-1:0]      vpn_full;
	logic [PAGE_W-1:0]      page_d;
	logic [TLB_ENTRIES-1:0] match_d;

	// resolve-cycle results
	logic               hit, fault, exhausted, room, map_vld;
	logic [TLB_W-1:0]   hit_idx;
	logic [FRAME_W-1:0] frame;
	logic [31:0]        frame_w, page_w, pa_w, off_mask;

	// output register
	logic rsp_valid_q;

	tfpt_ram #(
		.WIDTH (MAP_W),
		.DEPTH (PAGE_COUNT)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (page_d),
		.rdata (ram_rdata)
	);

	// page number and parallel tag compare on the incoming address
	always_comb begin
		vpn_full = ADDR_W'(req.vaddr >> OFFSET_BITS);
		page_d   = page_of(vpn_full[VPN_W-1:0]);
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			match_d[i] = tlb_valid_q[i] && (tlb_page_q[i] == page_d);
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfpt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		accept    = 1'b0;
		done      = 1'b0;
		clr_last  = (clr_q == PAGE_W'(PAGE_COUNT - 1));
		case (state_q)
			tfpt_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = tfpt_pkg::ST_IDLE;
				end
			end
			tfpt_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				accept    = req.valid;
				if (req.valid) begin
					state_d = tfpt_pkg::ST_BUSY;
				end
			end
			tfpt_pkg::ST_BUSY: begin
				// resolve only once the result register can take the new result
				done = !rsp_valid_q || rsp.ready;
				if (done) begin
					state_d = tfpt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tfpt_pkg::ST_CLEAR;
			end
		endcase
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == tfpt_pkg::ST_CLEAR && !clr_last) begin
			clr_q <= clr_q + PAGE_W'(1);
		end
	end

	// latch the request, page and match vector
	always_ff @(posedge clk) begin
		if (accept) begin
			va_s1    <= req.vaddr;
			page_s1  <= page_d;
			match_s1 <= match_d;
		end
	end

	// resolve: tlb first, then page table, then allocation
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				hit     = 1'b1;
				hit_idx = TLB_W'(i);
			end
		end
		map_vld   = ram_rdata[FRAME_W];
		room      = next_free_q < NF_W'(FRAME_COUNT);
		fault     = !hit && !map_vld && room;
		exhausted = !hit && !map_vld && !room;
		if (hit) begin
			frame = tlb_frame_q[hit_idx];
		end else if (map_vld) begin
			frame = ram_rdata[FRAME_W-1:0];
		end else if (room) begin
			frame = next_free_q[FRAME_W-1:0];
		end else begin
			frame = '0;
		end
		off_mask = (32'd1 << OFFSET_BITS) - 32'd1;
		frame_w  = 32'(frame);
		page_w   = 32'(page_s1);
		pa_w     = (frame_w << OFFSET_BITS) | (32'(va_s1) & off_mask);
	end

	// page table port: clearing pass, else write-back of a new mapping
	always_comb begin
		ram_re = accept;
		if (state_q == tfpt_pkg::ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = done && fault;
			ram_waddr = page_s1;
			ram_wdata = {1'b1, frame};
		end
	end

	// tlb valid bits, fifo pointer, allocation and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				tlb_valid_q[i] <= 1'b0;
			end
			fifo_q      <= '0;
			next_free_q <= '0;
			hits_q      <= '0;
			faults_q    <= '0;
			refs_q      <= '0;
		end else if (done) begin
			if (!hit) begin
				tlb_valid_q[fifo_q] <= 1'b1;
				fifo_q <= (fifo_q == TLB_W'(TLB_ENTRIES - 1)) ? '0 : fifo_q + TLB_W'(1);
			end
			if (fault) begin
				next_free_q <= next_free_q + NF_W'(1);
			end
			if (hit && hits_q != '1) begin
				hits_q <= hits_q + CNT_W'(1);
			end
			if (fault && faults_q != '1) begin
				faults_q <= faults_q + CNT_W'(1);
			end
			if (refs_q != '1) begin
				refs_q <= refs_q + CNT_W'(1);
			end
		end
	end

	// tlb tags and frames, filled on every miss
	always_ff @(posedge clk) begin
		if (done && !hit) begin
			tlb_page_q[fifo_q]  <= page_s1;
			tlb_frame_q[fifo_q] <= frame;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp.physical_address <= pa_w[ADDR_W-1:0];
			rsp.page_index       <= page_w[IDX_W-1:0];
			rsp.frame_index      <= frame_w[IDX_W-1:0];
			rsp.tlb_hit          <= hit;
			rsp.fault_flag       <= fault;
			rsp.frames_exhausted <= exhausted;
			rsp.hit_count        <= (hit && hits_q != '1) ? hits_q + CNT_W'(1) : hits_q;
			rsp.fault_count      <= (fault && faults_q != '1) ? faults_q + CNT_W'(1) : faults_q;
			rsp.reference_count  <= (refs_q != '1) ? refs_q + CNT_W'(1) : refs_q;
		end
	end

	assign rsp.valid = rsp_valid_q;

	// a page never sits in two tlb slots
	a_tlb_unique: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tfpt_pkg::ST_BUSY |-> $onehot0(match_s1))
		else $error("page matched more than one tlb slot");

	// allocation pointer stays within the frame range
	a_next_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= NF_W'(FRAME_COUNT))
		else $error("free frame pointer beyond frame count");

	// a hit never reports a fault or exhaustion
	a_hit_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp.tlb_hit && (rsp.fault_flag || rsp.frames_exhausted)))
		else $error("hit reported together with a fault");

	// no request is taken before the page table has been cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> $past(state_q) != tfpt_pkg::ST_CLEAR || clr_last ||
			state_q == tfpt_pkg::ST_IDLE)
		else $error("request accepted during clearing pass");

	// hits and faults never outnumber references
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp.hit_count <= rsp.reference_count &&
			rsp.fault_count <= rsp.reference_count)
		else $error("hit or fault count above reference count");

endmodule

@@ verif/testbench.sv @@
// testbench: self-checking bench for tlb_fifo_page_translator_unit, driven
// through the tfpt_req_if / tfpt_rsp_if channels with a tlb and page table predictor
// depends on tfpt_pkg, tfpt_if.sv and the design sources

module testbench;

	// field widths shared with the design
	localparam int unsigned ADDR_W = tfpt_pkg::ADDR_W;
	localparam int unsigned IDX_W  = tfpt_pkg::IDX_W;
	localparam int unsigned CNT_W  = tfpt_pkg::CNT_W;

	// block configuration, passed down to the dut and used by the predictor
	localparam int unsigned OFF_BITS = 8;
	localparam int unsigned PAGES    = 256;
	localparam int unsigned FRAMES   = 256;
	localparam int unsigned TLB_N    = 16;

	// cycles without any handshake before the run is declared hung
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned N_BLOCKS   = 28;
	localparam int unsigned BLOCK_LEN  = 50;

	// one translation result, field for field as on the response channel
	typedef struct packed {
		logic [ADDR_W-1:0] phys;
		logic [IDX_W-1:0]  page;
		logic [IDX_W-1:0]  frame;
		logic              hit;
		logic              fault;
		logic              exhausted;
		logic [CNT_W-1:0]  hits;
		logic [CNT_W-1:0]  faults;
		logic [CNT_W-1:0]  refs;
	} xlat_t;

	// directed row: address plus an optional hand-written expectation
	typedef struct {
		logic [ADDR_W-1:0] va;
		bit                typed;
		xlat_t             want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	tfpt_req_if req_ch ();
	tfpt_rsp_if rsp_ch ();

	tlb_fifo_page_translator_unit #(
		.OFFSET_BITS (OFF_BITS),
		.PAGE_COUNT  (PAGES),
		.FRAME_COUNT (FRAMES),
		.TLB_ENTRIES (TLB_N)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor state: tlb slots, round-robin fill pointer, page table,
	// free frame pointer and the three saturating counters
	// ---------------------------------------------------------------
	bit               tlb_v  [TLB_N];
	logic [IDX_W-1:0] tlb_pg [TLB_N] = '{default: '0};
	logic [IDX_W-1:0] tlb_fr [TLB_N] = '{default: '0};
	int unsigned      fill_ptr = 0;
	bit               pt_v   [PAGES];
	logic [IDX_W-1:0] pt_fr  [PAGES];
	int unsigned      free_frame = 0;
	logic [CNT_W-1:0] hits_total = '0;
	logic [CNT_W-1:0] faults_total = '0;
	logic [CNT_W-1:0] refs_total = '0;

	// translations still owed by the dut, oldest first
	xlat_t pending_xlat [$];

	// run statistics and failure bookkeeping
	int unsigned n_items = 0;
	int unsigned n_directed = 0;
	int unsigned n_hit = 0;
	int unsigned n_fault = 0;
	int unsigned n_table = 0;
	int unsigned n_exh = 0;
	int unsigned n_mismatch = 0;
	int unsigned n_unexpected = 0;
	int unsigned n_report = 0;

	// shared between the two drivers; cleared for the final stretch of the run
	bit idle_on = 1'b1;

	string xlat_field [9] = '{"physical_address", "page_index", "frame_index", "tlb_hit",
		"fault_flag", "frames_exhausted", "hit_count", "fault_count", "reference_count"};

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic xlat_t mk_xlat(logic [ADDR_W-1:0] phys, logic [IDX_W-1:0] page,
			logic [IDX_W-1:0] frame, logic hit, logic fault, logic exhausted,
			logic [CNT_W-1:0] hits, logic [CNT_W-1:0] faults, logic [CNT_W-1:0] refs);
		xlat_t r;
		r.phys      = phys;
		r.page      = page;
		r.frame     = frame;
		r.hit       = hit;
		r.fault     = fault;
		r.exhausted = exhausted;
		r.hits      = hits;
		r.faults    = faults;
		r.refs      = refs;
		return r;
	endfunction

	// translate one virtual address and advance the predictor state
	function automatic xlat_t translate(logic [ADDR_W-1:0] va);
		xlat_t       r;
		int unsigned pg;
		int unsigned fr;
		int unsigned off;
		int unsigned slot;
		int unsigned i;
		bit          hit;
		r   = '0;
		off = 32'(va) & ((32'd1 << OFF_BITS) - 32'd1);
		pg  = (32'(va) >> OFF_BITS) % PAGES;
		fr  = 0;
		hit = 1'b0;
		// lowest matching valid slot wins
		for (i = 0; i < TLB_N; i++) begin
			if (!hit && tlb_v[i] && 32'(tlb_pg[i]) == pg) begin
				hit = 1'b1;
				fr  = 32'(tlb_fr[i]);
			end
		end
		if (hit) begin
			hits_total = sat_inc(hits_total);
		end else begin
			if (pt_v[pg]) begin
				fr = 32'(pt_fr[pg]);
			end else if (free_frame < FRAMES) begin
				// unmapped page: hand out the lowest free frame
				fr           = free_frame;
				free_frame   = free_frame + 1;
				pt_v[pg]     = 1'b1;
				pt_fr[pg]    = IDX_W'(fr);
				r.fault      = 1'b1;
				faults_total = sat_inc(faults_total);
			end else begin
				// no frame left: frame 0, page table untouched
				fr          = 0;
				r.exhausted = 1'b1;
			end
			// every miss refills the slot under the round-robin pointer
			slot         = fill_ptr % TLB_N;
			tlb_v[slot]  = 1'b1;
			tlb_pg[slot] = IDX_W'(pg);
			tlb_fr[slot] = IDX_W'(fr);
			fill_ptr     = (slot + 1) % TLB_N;
		end
		refs_total = sat_inc(refs_total);
		r.phys   = ADDR_W'((fr << OFF_BITS) | off);
		r.page   = IDX_W'(pg);
		r.frame  = IDX_W'(fr);
		r.hit    = hit;
		r.hits   = hits_total;
		r.faults = faults_total;
		r.refs   = refs_total;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// request driver: called at a falling edge, returns at the falling
	// edge after the request was taken, with valid still high
	// ---------------------------------------------------------------
	task automatic send_va(input logic [ADDR_W-1:0] va, input bit typed, input xlat_t want);
		xlat_t predicted;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.vaddr <= va;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		// request taken at this edge: predict and queue its result
		predicted = translate(va);
		pending_xlat.push_back(typed ? want : predicted);
		n_items++;
		if (predicted.hit)
			n_hit++;
		else if (predicted.fault)
			n_fault++;
		else if (predicted.exhausted)
			n_exh++;
		else
			n_table++;
		@(negedge clk);
	endtask

	// hold off new requests until every owed result has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_xlat.size() != 0);
	endtask

	// ---------------------------------------------------------------
	// response side: random back-pressure in bursts of stalled cycles
	// ---------------------------------------------------------------
	initial begin
		int unsigned stall_left;
		stall_left   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// compare one taken result against the oldest owed translation
	task automatic check_result();
		xlat_t            want;
		xlat_t            got;
		logic [CNT_W-1:0] w [9];
		logic [CNT_W-1:0] g [9];
		string            msg;
		int               i;
		got = mk_xlat(rsp_ch.physical_address, rsp_ch.page_index, rsp_ch.frame_index,
			rsp_ch.tlb_hit, rsp_ch.fault_flag, rsp_ch.frames_exhausted,
			rsp_ch.hit_count, rsp_ch.fault_count, rsp_ch.reference_count);
		if (pending_xlat.size() == 0) begin
			n_unexpected++;
			n_report++;
			if (n_report <= 10)
				$display("[%0t] unexpected result: pa=%h page=%h frame=%h", $realtime,
					got.phys, got.page, got.frame);
			return;
		end
		want = pending_xlat.pop_front();
		w = '{want.phys, want.page, want.frame, want.hit, want.fault, want.exhausted,
			want.hits, want.faults, want.refs};
		g = '{got.phys, got.page, got.frame, got.hit, got.fault, got.exhausted,
			got.hits, got.faults, got.refs};
		msg = "";
		for (i = 0; i < 9; i++) begin
			if (w[i] !== g[i])
				msg = {msg, $sformatf(" %s exp %0h got %0h;", xlat_field[i], w[i], g[i])};
		end
		if (msg != "") begin
			n_mismatch++;
			n_report++;
			if (n_report <= 10)
				$display("[%0t] mismatch for page %h:%s", $realtime, want.page, msg);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			check_result();
	end

	// ---------------------------------------------------------------
	// watchdog: any handshake on either channel counts as progress;
	// the clearing pass after reset fits well inside the limit
	// ---------------------------------------------------------------
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no request or result moved for %0d cycles, %0d results owed",
			IDLE_LIMIT, pending_xlat.size());
		$display("FAIL tlb_fifo_page_translator_unit");
		$finish;
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	initial begin
		dir_row_t          dir_tab [25];
		logic [IDX_W-1:0]  ws [20];
		int unsigned       ws_n;
		int unsigned       blk;
		int unsigned       k;
		logic [IDX_W-1:0]  pg;
		logic [ADDR_W-1:0] va;

		req_ch.valid = 1'b0;
		req_ch.vaddr = '0;
		arst_n       = 1'b0;

		// directed part: the first rows and the two refills after eviction are
		// worked out by hand, the rest goes through the predictor
		dir_tab = '{
			// first touch after reset: fault on page 0, frame 0
			'{16'h0000, 1'b1, mk_xlat(16'h0000, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0,
				32'd0, 32'd1, 32'd1)},
			// same page, highest offset: tlb hit
			'{16'h00FF, 1'b1, mk_xlat(16'h00FF, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0,
				32'd1, 32'd1, 32'd2)},
			// highest page, gets frame 1
			'{16'hFFFF, 1'b1, mk_xlat(16'h01FF, 8'hFF, 8'h01, 1'b0, 1'b1, 1'b0,
				32'd1, 32'd2, 32'd3)},
			'{16'hFF00, 1'b1, mk_xlat(16'h0100, 8'hFF, 8'h01, 1'b1, 1'b0, 1'b0,
				32'd2, 32'd2, 32'd4)},
			// sixteen new pages wrap the fill pointer and evict pages 0 and ff
			'{16'h01A5, 1'b0, '0}, '{16'h025A, 1'b0, '0}, '{16'h0333, 1'b0, '0},
			'{16'h04CC, 1'b0, '0}, '{16'h0501, 1'b0, '0}, '{16'h06FE, 1'b0, '0},
			'{16'h0780, 1'b0, '0}, '{16'h087F, 1'b0, '0}, '{16'h0910, 1'b0, '0},
			'{16'h0AEF, 1'b0, '0}, '{16'h0B55, 1'b0, '0}, '{16'h0CAA, 1'b0, '0},
			'{16'h0D0F, 1'b0, '0}, '{16'h0EF0, 1'b0, '0}, '{16'h0F3C, 1'b0, '0},
			'{16'h10C3, 1'b0, '0},
			// evicted pages come back from the page table, no new fault
			'{16'h0080, 1'b1, mk_xlat(16'h0080, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0,
				32'd2, 32'd18, 32'd21)},
			'{16'hFF7F, 1'b1, mk_xlat(16'h017F, 8'hFF, 8'h01, 1'b0, 1'b0, 1'b0,
				32'd2, 32'd18, 32'd22)},
			// top address bit alone, then all bits but the top one
			'{16'h8000, 1'b0, '0}, '{16'h7FFF, 1'b0, '0},
			// page 1 was pushed out by the first of the two refills above
			'{16'h0155, 1'b0, '0}
		};

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < 25; k++)
			send_va(dir_tab[k].va, dir_tab[k].typed, dir_tab[k].want);
		n_directed = n_items;

		// random part in blocks: working-set traffic to build up tlb hits,
		// then uniform traffic that maps most of the page table, then
		// working-set traffic again with both sides running flat out
		for (blk = 0; blk < N_BLOCKS; blk++) begin
			idle_on = (blk < 20) ? ($urandom_range(0, 3) != 0) : 1'b0;
			ws_n = $urandom_range(2, 20);
			for (k = 0; k < ws_n; k++)
				ws[k] = IDX_W'($urandom_range(0, PAGES - 1));
			for (k = 0; k < BLOCK_LEN; k++) begin
				if (blk >= 10 && blk < 20) begin
					va = ADDR_W'($urandom_range(0, 16'hFFFF));
				end else begin
					// mostly the working set, now and then a stray page
					if ($urandom_range(0, 7) == 0)
						pg = IDX_W'($urandom_range(0, PAGES - 1));
					else
						pg = ws[$urandom_range(0, ws_n - 1)];
					va = {pg, 8'($urandom_range(0, 255))};
				end
				send_va(va, 1'b0, '0);
			end
			// let the pipeline run dry at the phase boundaries and midway through the uniform phase
			if (blk == 9 || blk == 14 || blk == 19)
				wait_drained();
		end

		// wind down: everything back, then a quiet stretch to catch strays
		wait_drained();
		repeat (8) @(negedge clk);

		$display("translated %0d addresses (%0d directed): %0d tlb hits, %0d faults,",
			n_items, n_directed, n_hit, n_fault);
		$display("  %0d from page table, %0d exhausted; %0d of %0d frames handed out",
			n_table, n_exh, free_frame, FRAMES);
		$display("%0d mismatching and %0d unexpected results", n_mismatch, n_unexpected);
		if (n_mismatch == 0 && n_unexpected == 0) begin
			$display("PASS tlb_fifo_page_translator_unit");
		end else begin
			$display("FAIL tlb_fifo_page_translator_unit");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/tfpt_pkg.sv
design/tfpt_if.sv
design/tfpt_ram.sv
design/tlb_fifo_page_translator_unit.sv
verif/testbench.sv
